@@ hw/rtl/btbm_pkg.sv @@
package btbm_pkg;

  localparam int FUNC_W   = 3;
  localparam int ADDR_W   = 12;
  localparam int SIZE_W   = 12;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 13;
  localparam int TAG_W    = 14;
  localparam int INUSE_BIT = 13;

  localparam logic [FUNC_W-1:0] FUNC_FORMAT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_MARK_ALLOC = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK_FREE  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SPLIT      = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_MERGE      = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INUSE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_SMALL = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

endpackage

@@ hw/rtl/btbm_req_if.sv @@
interface btbm_req_if;
  import btbm_pkg::*;

  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ADDR_W-1:0] block_addr;
  logic [SIZE_W-1:0] block_size;

  modport source (output valid, output func, output block_addr, output block_size,
                  input ready);
  modport sink (input valid, input func, input block_addr, input block_size,
                output ready);
endinterface

@@ hw/rtl/btbm_rsp_if.sv @@
interface btbm_rsp_if;
  import btbm_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   result_addr;
  logic                is_free;
  logic [SIZE_W-1:0]   data_size;
  logic [TOTAL_W-1:0]  total_size;
  logic [TOTAL_W-1:0]  next_addr;

  modport source (output valid, output status, output result_addr, output is_free,
                  output data_size, output total_size, output next_addr, input ready);
  modport sink (input valid, input status, input result_addr, input is_free,
                input data_size, input total_size, input next_addr, output ready);
endinterface

@@ hw/rtl/btbm_ram.sv @@
module btbm_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ hw/rtl/boundary_tag_block_manager_unit.sv @@
// Boundary-tag block manager. Each request formats, marks, splits or merges one block in a
// tag RAM of HEAP_WORDS words with a single read/write port, whose read data is registered
// and arrives in the cycle after the address. Every tag read and every tag write holds the
// RAM port, and a merge with both neighbours needs four reads and four writes. After reset
// the RAM is cleared one word per cycle, so the request channel stays not-ready until the
// last word is cleared. A finished result sits in an output register, and the next request
// is taken while it waits.
module boundary_tag_block_manager_unit #(
  parameter int HEAP_WORDS = 4096,
  parameter int TAG_WORDS  = 1
) (
  input logic       clk,
  input logic       rst,
  btbm_req_if.sink  req,
  btbm_rsp_if.source rsp
);
  import btbm_pkg::*;

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int CW = ((AW + 1 > TAG_W) ? AW + 1 : TAG_W) + 3;
  localparam logic [CW-1:0] HEAP = CW'(HEAP_WORDS);
  localparam logic [CW-1:0] TAGC = CW'(TAG_WORDS);
  localparam logic [CW-1:0] BTC  = CW'(2 * TAG_WORDS);
  localparam logic [AW-1:0] LAST = AW'(HEAP_WORDS - 1);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_DISP   = 4'd1;
  localparam logic [3:0] ST_HEVAL  = 4'd2;
  localparam logic [3:0] ST_PTEVAL = 4'd3;
  localparam logic [3:0] ST_PHEVAL = 4'd4;
  localparam logic [3:0] ST_NEXT   = 4'd5;
  localparam logic [3:0] ST_NHEVAL = 4'd6;
  localparam logic [3:0] ST_WH     = 4'd7;
  localparam logic [3:0] ST_WT     = 4'd8;
  localparam logic [3:0] ST_DONE   = 4'd9;

  localparam logic [1:0] AFT_DONE  = 2'd0;
  localparam logic [1:0] AFT_SPLIT = 2'd1;
  localparam logic [1:0] AFT_NEXT  = 2'd2;

  function automatic logic fits(input logic [CW-1:0] a, input logic [CW-1:0] sz);
    return (a + sz + BTC) <= HEAP;
  endfunction

  logic [3:0]          state, state_next;
  logic                clr_busy, clr_busy_next;
  logic [AW-1:0]       clr_addr, clr_addr_next;
  logic [FUNC_W-1:0]   func_q, func_q_next;
  logic [CW-1:0]       a_q, a_q_next;
  logic [SIZE_W-1:0]   s_q, s_q_next;
  logic [STATUS_W-1:0] status_q, status_q_next;
  logic [CW-1:0]       res_q, res_q_next;
  logic [TAG_W-1:0]    head_q, head_q_next;
  logic [CW-1:0]       csize, csize_next;
  logic [CW-1:0]       p_q, p_q_next;
  logic [CW-1:0]       rest, rest_next;
  logic [CW-1:0]       blk_addr, blk_addr_next;
  logic [CW-1:0]       blk_size, blk_size_next;
  logic [1:0]          aft, aft_next;
  logic                head_upd, head_upd_next;

  logic                out_valid, out_valid_next;
  logic [STATUS_W-1:0] o_status, o_status_next;
  logic [ADDR_W-1:0]   o_addr, o_addr_next;
  logic                o_free, o_free_next;
  logic [SIZE_W-1:0]   o_dsize, o_dsize_next;
  logic [TOTAL_W-1:0]  o_total, o_total_next;
  logic [TOTAL_W-1:0]  o_next, o_next_next;

  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [TAG_W-1:0]    mem_wdata;
  logic [TAG_W-1:0]    mem_rdata;
  logic                req_ready;

  btbm_ram #(.WIDTH(TAG_W), .DEPTH(HEAP_WORDS)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  assign req_ready = (state == ST_IDLE) && !clr_busy;
  assign req.ready = req_ready;

  always_comb begin
    logic [CW-1:0]      rd_size;
    logic [CW-1:0]      calc_a;
    logic [CW-1:0]      calc_m;
    logic [TAG_W-1:0]   wval;
    logic [TOTAL_W-1:0] tot;

    state_next    = state;
    clr_busy_next = clr_busy;
    clr_addr_next = clr_addr;
    func_q_next   = func_q;
    a_q_next      = a_q;
    s_q_next      = s_q;
    status_q_next = status_q;
    res_q_next    = res_q;
    head_q_next   = head_q;
    csize_next    = csize;
    p_q_next      = p_q;
    rest_next     = rest;
    blk_addr_next = blk_addr;
    blk_size_next = blk_size;
    aft_next      = aft;
    head_upd_next = head_upd;
    out_valid_next = out_valid;
    o_status_next = o_status;
    o_addr_next   = o_addr;
    o_free_next   = o_free;
    o_dsize_next  = o_dsize;
    o_total_next  = o_total;
    o_next_next   = o_next;
    mem_we        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;
    rd_size       = CW'(mem_rdata[TAG_W-2:0]);
    calc_a        = '0;
    calc_m        = '0;
    wval          = '0;
    tot           = '0;

    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    if (clr_busy) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr;
      clr_addr_next = clr_addr + 1'b1;
      if (clr_addr == LAST) begin
        clr_busy_next = 1'b0;
      end
    end

    case (state)
      ST_IDLE: begin
        if (req.valid && req_ready) begin
          func_q_next = req.func;
          a_q_next    = CW'(req.block_addr);
          s_q_next    = req.block_size;
          state_next  = ST_DISP;
        end
      end
      ST_DISP: begin
        res_q_next    = a_q;
        status_q_next = STATUS_OK;
        head_q_next   = '0;
        if (func_q == FUNC_FORMAT) begin
          if (fits(a_q, CW'(s_q))) begin
            blk_addr_next = a_q;
            blk_size_next = CW'(s_q);
            aft_next      = AFT_DONE;
            head_upd_next = 1'b1;
            state_next    = ST_WH;
          end else begin
            status_q_next = STATUS_RANGE;
            state_next    = ST_DONE;
          end
        end else if (func_q <= FUNC_MERGE && a_q < HEAP) begin
          mem_addr   = a_q[AW-1:0];
          state_next = ST_HEVAL;
        end else begin
          status_q_next = STATUS_RANGE;
          state_next    = ST_DONE;
        end
      end
      ST_HEVAL: begin
        head_q_next = mem_rdata;
        state_next  = ST_DONE;
        if (!fits(a_q, rd_size)) begin
          status_q_next = STATUS_RANGE;
        end else if (func_q == FUNC_MARK_ALLOC || func_q == FUNC_MARK_FREE) begin
          wval = mem_rdata;
          wval[INUSE_BIT] = (func_q == FUNC_MARK_ALLOC);
          mem_we      = 1'b1;
          mem_addr    = a_q[AW-1:0];
          mem_wdata   = wval;
          head_q_next = wval;
        end else if (mem_rdata[INUSE_BIT]) begin
          status_q_next = STATUS_INUSE;
        end else if (func_q == FUNC_SPLIT) begin
          if (rd_size < CW'(s_q) + BTC + BTC) begin
            status_q_next = STATUS_SMALL;
          end else begin
            rest_next     = rd_size - CW'(s_q) - BTC;
            blk_addr_next = a_q;
            blk_size_next = CW'(s_q);
            aft_next      = AFT_SPLIT;
            head_upd_next = 1'b1;
            state_next    = ST_WH;
          end
        end else begin
          csize_next = rd_size;
          if (a_q >= TAGC) begin
            calc_a     = a_q - TAGC;
            mem_addr   = calc_a[AW-1:0];
            state_next = ST_PTEVAL;
          end else begin
            state_next = ST_NEXT;
          end
        end
      end
      ST_PTEVAL: begin
        if (rd_size != '0 && rd_size <= a_q) begin
          calc_a     = a_q - rd_size;
          p_q_next   = calc_a;
          mem_addr   = calc_a[AW-1:0];
          state_next = ST_PHEVAL;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_PHEVAL: begin
        calc_m     = rd_size + csize + BTC;
        state_next = ST_NEXT;
        if (!mem_rdata[INUSE_BIT] && fits(p_q, calc_m)) begin
          res_q_next    = p_q;
          csize_next    = calc_m;
          blk_addr_next = p_q;
          blk_size_next = calc_m;
          aft_next      = AFT_NEXT;
          head_upd_next = 1'b1;
          state_next    = ST_WH;
        end
      end
      ST_NEXT: begin
        calc_a = res_q + csize + BTC;
        if (calc_a < HEAP) begin
          mem_addr   = calc_a[AW-1:0];
          state_next = ST_NHEVAL;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_NHEVAL: begin
        calc_m     = csize + rd_size + BTC;
        state_next = ST_DONE;
        if (mem_rdata != '0 && !mem_rdata[INUSE_BIT] && fits(res_q, calc_m)) begin
          blk_addr_next = res_q;
          blk_size_next = calc_m;
          aft_next      = AFT_DONE;
          head_upd_next = 1'b1;
          state_next    = ST_WH;
        end
      end
      ST_WH: begin
        wval      = {1'b0, blk_size[TAG_W-2:0]};
        mem_we    = 1'b1;
        mem_addr  = blk_addr[AW-1:0];
        mem_wdata = wval;
        if (head_upd) begin
          head_q_next = wval;
        end
        state_next = ST_WT;
      end
      ST_WT: begin
        calc_a    = blk_addr + TAGC + blk_size;
        calc_m    = blk_size + BTC;
        mem_we    = 1'b1;
        mem_addr  = calc_a[AW-1:0];
        mem_wdata = {1'b0, calc_m[TAG_W-2:0]};
        case (aft)
          AFT_SPLIT: begin
            blk_addr_next = blk_addr + blk_size + BTC;
            blk_size_next = rest;
            aft_next      = AFT_DONE;
            head_upd_next = 1'b0;
            state_next    = ST_WH;
          end
          AFT_NEXT: begin
            state_next = ST_NEXT;
          end
          default: begin
            state_next = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_valid || rsp.ready) begin
          tot            = head_q[TAG_W-2:0] + TOTAL_W'(2 * TAG_WORDS);
          out_valid_next = 1'b1;
          o_status_next  = status_q;
          o_addr_next    = res_q[ADDR_W-1:0];
          if (status_q == STATUS_RANGE) begin
            o_free_next  = 1'b0;
            o_dsize_next = '0;
            o_total_next = '0;
            o_next_next  = '0;
          end else begin
            o_free_next  = !head_q[INUSE_BIT];
            o_dsize_next = head_q[SIZE_W-1:0];
            o_total_next = tot;
            o_next_next  = res_q[TOTAL_W-1:0] + tot;
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      clr_busy  <= 1'b1;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_busy  <= clr_busy_next;
      clr_addr  <= clr_addr_next;
      out_valid <= out_valid_next;
    end
    func_q   <= func_q_next;
    a_q      <= a_q_next;
    s_q      <= s_q_next;
    status_q <= status_q_next;
    res_q    <= res_q_next;
    head_q   <= head_q_next;
    csize    <= csize_next;
    p_q      <= p_q_next;
    rest     <= rest_next;
    blk_addr <= blk_addr_next;
    blk_size <= blk_size_next;
    aft      <= aft_next;
    head_upd <= head_upd_next;
    o_status <= o_status_next;
    o_addr   <= o_addr_next;
    o_free   <= o_free_next;
    o_dsize  <= o_dsize_next;
    o_total  <= o_total_next;
    o_next   <= o_next_next;
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = o_status;
  assign rsp.result_addr = o_addr;
  assign rsp.is_free     = o_free;
  assign rsp.data_size   = o_dsize;
  assign rsp.total_size  = o_total;
  assign rsp.next_addr   = o_next;

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status == STATUS_RANGE) |->
      (!rsp.is_free && rsp.data_size == '0 && rsp.total_size == '0 && rsp.next_addr == '0))
    else $error("out of range result carries nonzero fields");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && !clr_busy) |-> !mem_we)
    else $error("tag write while idle");

  a_clear_blocks_req: assert property (@(posedge clk) disable iff (rst)
    clr_busy |=> (state == ST_IDLE || !$past(clr_busy)))
    else $error("request started during clearing pass");

  a_format_ok: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && func_q == FUNC_FORMAT && status_q == STATUS_OK) |->
      (head_q[TAG_W-2:0] == TOTAL_W'(s_q) && !head_q[INUSE_BIT]))
    else $error("formatted head does not match request size");

endmodule

@@ test/testbench.sv @@
module testbench;
  import btbm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int HEAP_DEPTH = 4096;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [TAG_W-1:0] INUSE_TAG = 14'h2000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_addr;
    logic                is_free;
    logic [SIZE_W-1:0]   data_size;
    logic [TOTAL_W-1:0]  total_size;
    logic [TOTAL_W-1:0]  next_addr;
  } block_report_t;

  logic clk;
  logic rst;
  int errors;
  int cycles;
  bit steady;
  int hold_cycles;
  logic [TAG_W-1:0] heap [HEAP_DEPTH];
  block_report_t pending_reports[$];
  block_report_t want;

  btbm_req_if req();
  btbm_rsp_if rsp();

  boundary_tag_block_manager_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // tag store mirror
  function automatic logic [TAG_W-1:0] peek_tag(int unsigned a);
    return (a < HEAP_DEPTH) ? heap[a] : '0;
  endfunction

  function automatic void poke_tag(int unsigned a, logic [TAG_W-1:0] v);
    if (a < HEAP_DEPTH) heap[a] = v;
  endfunction

  function automatic bit block_fits(int unsigned a, int unsigned sz);
    return (64'(a) + 2 + sz) <= HEAP_DEPTH;
  endfunction

  function automatic void lay_free_block(int unsigned a, int unsigned sz);
    poke_tag(a, TAG_W'(sz & 32'h1FFF));
    poke_tag(a + 1 + sz, TAG_W'((sz + 2) & 32'h1FFF));
  endfunction

  function automatic int unsigned coalesce_block(int unsigned a, int unsigned sz);
    int unsigned cur, csz, t, p, m, n;
    logic [TAG_W-1:0] ph, nh;
    cur = a;
    csz = sz;
    if (a >= 1) begin
      ph = peek_tag(a - 1);
      t = 32'(ph[12:0]);
      if (t != 0 && t <= a) begin
        p = a - t;
        ph = peek_tag(p);
        if (!ph[INUSE_BIT]) begin
          m = 32'(ph[12:0]) + csz + 2;
          if (block_fits(p, m)) begin
            lay_free_block(p, m);
            cur = p;
            csz = m;
          end
        end
      end
    end
    n = cur + csz + 2;
    if (n < HEAP_DEPTH) begin
      nh = peek_tag(n);
      if (nh != '0 && !nh[INUSE_BIT]) begin
        m = csz + 32'(nh[12:0]) + 2;
        if (block_fits(cur, m)) lay_free_block(cur, m);
      end
    end
    return cur;
  endfunction

  function automatic block_report_t block_op_outcome(logic [FUNC_W-1:0] f,
                                                     logic [ADDR_W-1:0] a_in,
                                                     logic [SIZE_W-1:0] s_in);
    block_report_t r;
    int unsigned a, s, sz, rest, res;
    logic [TAG_W-1:0] h;
    a = 32'(a_in);
    s = 32'(s_in);
    res = a;
    r = '0;
    r.status = STATUS_OK;
    case (f)
      FUNC_FORMAT: begin
        if (!block_fits(a, s)) r.status = STATUS_RANGE;
        else lay_free_block(a, s);
      end
      FUNC_MARK_ALLOC, FUNC_MARK_FREE, FUNC_SPLIT, FUNC_MERGE: begin
        h = peek_tag(a);
        sz = 32'(h[12:0]);
        if (!block_fits(a, sz)) begin
          r.status = STATUS_RANGE;
        end else if (f == FUNC_MARK_ALLOC) begin
          poke_tag(a, h | INUSE_TAG);
        end else if (f == FUNC_MARK_FREE) begin
          poke_tag(a, h & ~INUSE_TAG);
        end else if (h[INUSE_BIT]) begin
          r.status = STATUS_INUSE;
        end else if (f == FUNC_SPLIT) begin
          if (sz < s + 4) begin
            r.status = STATUS_SMALL;
          end else begin
            rest = sz - s - 2;
            lay_free_block(a, s);
            lay_free_block(a + s + 2, rest);
          end
        end else begin
          res = coalesce_block(a, sz);
        end
      end
      default: r.status = STATUS_RANGE;
    endcase
    r.result_addr = ADDR_W'(res);
    if (r.status != STATUS_RANGE) begin
      h = peek_tag(res);
      r.is_free = !h[INUSE_BIT];
      r.data_size = h[11:0];
      r.total_size = TOTAL_W'(h[12:0] + 2);
      r.next_addr = TOTAL_W'(res + r.total_size);
    end
    return r;
  endfunction

  // response checking
  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transfer with nothing pending");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", 16'(want.status), 16'(rsp.status));
        check_field("result_addr", 16'(want.result_addr), 16'(rsp.result_addr));
        check_field("is_free", 16'(want.is_free), 16'(rsp.is_free));
        check_field("data_size", 16'(want.data_size), 16'(rsp.data_size));
        check_field("total_size", 16'(want.total_size), 16'(rsp.total_size));
        check_field("next_addr", 16'(want.next_addr), 16'(rsp.next_addr));
      end
    end
  end

  // result side ready, with random and forced hold-offs
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= steady || ($urandom_range(0, 99) >= 22);
      end
    end
  end

  task automatic send_op(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
                         input logic [SIZE_W-1:0] s, output block_report_t r);
    while (!steady && $urandom_range(0, 99) < 22) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func <= f;
    req.block_addr <= a;
    req.block_size <= s;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    r = block_op_outcome(f, a, s);
    pending_reports.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_reports();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic test_edges();
    block_report_t r;
    send_op(FUNC_FORMAT, 0, 4094, r);
    send_op(FUNC_MERGE, 0, 12'hFFF, r);
    send_op(FUNC_FORMAT, 1, 4094, r);
    send_op(FUNC_FORMAT, 4095, 0, r);
    send_op(FUNC_MARK_ALLOC, 4095, 0, r);
    send_op(FUNC_FORMAT, 4094, 0, r);
    send_op(FUNC_SPLIT, 4094, 0, r);
    send_op(FUNC_MERGE, 4094, 0, r);
    send_op(FUNC_FORMAT, 4095, 4095, r);
    send_op(3'd5, 12'hFFF, 12'hFFF, r);
    send_op(3'd7, 12'h000, 12'h000, r);
    drain_reports();
  endtask

  task automatic test_status_codes();
    block_report_t r;
    send_op(FUNC_FORMAT, 12, 20, r);
    send_op(FUNC_FORMAT, 34, 5, r);
    send_op(FUNC_MARK_ALLOC, 12, 0, r);
    send_op(FUNC_SPLIT, 12, 4, r);
    send_op(FUNC_MERGE, 12, 0, r);
    send_op(FUNC_MARK_FREE, 12, 0, r);
    send_op(FUNC_SPLIT, 12, 17, r);
    send_op(FUNC_SPLIT, 12, 16, r);
    send_op(FUNC_MERGE, 30, 0, r);
    send_op(FUNC_FORMAT, 100, 3, r);
    send_op(FUNC_FORMAT, 105, 3, r);
    send_op(FUNC_MARK_ALLOC, 100, 0, r);
    send_op(FUNC_MERGE, 105, 0, r);
    send_op(FUNC_FORMAT, 200, 4, r);
    send_op(FUNC_SPLIT, 200, 0, r);
    drain_reports();
  endtask

  // result side stalls long enough for the request side to back up
  task automatic test_backpressure();
    block_report_t r;
    int unsigned a;
    hold_cycles = 200;
    send_op(FUNC_FORMAT, 3000, 120, r);
    a = 3000;
    repeat (20) begin
      send_op(FUNC_SPLIT, ADDR_W'(a), 4, r);
      a = a + 6;
    end
    for (int k = 0; k < 10; k++) send_op(FUNC_MARK_ALLOC, ADDR_W'(3006 + 12 * k), 0, r);
    for (int k = 0; k < 10; k++) send_op(FUNC_MERGE, ADDR_W'(3000 + 12 * k), 0, r);
    drain_reports();
  endtask

  task automatic test_random_sequences(input int n_items);
    block_report_t r;
    int unsigned base, a, s, sz, mode, round, ops;
    int sent;
    logic [FUNC_W-1:0] f;
    logic [TAG_W-1:0] h;
    int unsigned heads[$];
    sent = 0;
    round = 0;
    while (sent < n_items) begin
      round++;
      steady = (round >= 12 && round < 18);
      if ($urandom_range(0, 9) == 0) base = 4095 - $urandom_range(0, 40);
      else base = $urandom_range(0, 3800);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(8, 240);
      send_op(FUNC_FORMAT, ADDR_W'(base), SIZE_W'(s), r);
      sent++;
      heads.delete();
      heads.push_back(base);
      ops = $urandom_range(15, 35);
      repeat (ops) begin
        if ($urandom_range(0, 99) < 88) a = heads[$urandom_range(0, heads.size() - 1)];
        else a = (base + $urandom_range(0, 260)) % HEAP_DEPTH;
        h = heap[a];
        sz = 32'(h[12:0]);
        mode = $urandom_range(0, 99);
        s = 0;
        if (mode < 30) begin
          f = FUNC_SPLIT;
          s = (sz >= 4) ? $urandom_range(0, sz - 2) : $urandom_range(0, 6);
        end else if (mode < 50) begin
          f = FUNC_MARK_ALLOC;
        end else if (mode < 72) begin
          f = FUNC_MARK_FREE;
        end else if (mode < 94) begin
          f = FUNC_MERGE;
        end else if (mode < 97) begin
          f = FUNC_FORMAT;
          s = $urandom_range(0, 60);
        end else begin
          f = FUNC_W'($urandom_range(0, 7));
          a = $urandom_range(0, 4095);
          s = $urandom_range(0, 4095);
        end
        send_op(f, ADDR_W'(a), SIZE_W'(s), r);
        sent++;
        if (r.status != STATUS_RANGE) begin
          heads.push_back(32'(r.result_addr));
          if (32'(r.next_addr) < HEAP_DEPTH) heads.push_back(32'(r.next_addr));
          while (heads.size() > 40) void'(heads.pop_front());
        end
      end
      if (round % 10 == 0) drain_reports();
    end
    steady = 1'b0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    steady = 1'b0;
    hold_cycles = 0;
    for (int i = 0; i < HEAP_DEPTH; i++) heap[i] = '0;
    rst = 1'b1;
    req.valid = 1'b0;
    req.func = FUNC_FORMAT;
    req.block_addr = '0;
    req.block_size = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_edges();
    test_status_codes();
    test_backpressure();
    test_random_sequences(1270);
    drain_reports();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
